@@ rtl/meu_pkg.sv @@
// ----------------------------------------------------------------------------
// meu_pkg
// Shared types, codes and the entity name table for the entity unescaper.
// ----------------------------------------------------------------------------
package meu_pkg;

    localparam int NameMaxLen = 4;
    localparam int NameCount  = 9;

    // result status codes
    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_UNKNOWN   = 2'd1;
    localparam logic [1:0] ST_FORBIDDEN = 2'd2;
    localparam logic [1:0] ST_OPEN_END  = 2'd3;

    // special bytes
    localparam logic [7:0] CH_AMP   = 8'h26;
    localparam logic [7:0] CH_SEMI  = 8'h3B;
    localparam logic [7:0] CH_APOS  = 8'h27;
    localparam logic [7:0] CH_QUOT  = 8'h22;
    localparam logic [7:0] CH_LT    = 8'h3C;
    localparam logic [7:0] CH_GT    = 8'h3E;

    // name table: text packed with the first byte in [7:0]
    localparam logic [2:0] NAME_LEN [NameCount] = '{
        3'd4, 3'd4, 3'd2, 3'd2, 3'd3, 3'd2, 3'd2, 3'd3, 3'd4
    };
    localparam logic [31:0] NAME_TEXT [NameCount] = '{
        32'h736F7061,   // apos
        32'h746F7571,   // quot
        32'h0000746C,   // lt
        32'h00007467,   // gt
        32'h00706D61,   // amp
        32'h00007263,   // cr
        32'h0000666C,   // lf
        32'h00626174,   // tab
        32'h63617073    // spac
    };
    localparam logic [7:0] NAME_VALUE [NameCount] = '{
        8'h27, 8'h22, 8'h3C, 8'h3E, 8'h26, 8'h0D, 8'h0A, 8'h09, 8'h20
    };

    typedef struct packed {
        logic             in_entity;
        logic [3:0][7:0]  name_chars;
        logic [2:0]       name_length;
        logic             error_seen;
    } dec_state_t;

    typedef struct packed {
        logic [7:0] char_out;
        logic       char_valid;
        logic [1:0] status;
        logic       last_out;
    } result_t;

    typedef struct packed {
        logic       hit;
        logic [7:0] value;
    } lookup_t;

    // parallel match of the collected name against all known names
    function automatic lookup_t lookup_name(logic [3:0][7:0] chars, logic [2:0] len);
        lookup_t    r;
        logic       same;
        logic [31:0] text;
        r = '0;
        for (int k = NameCount - 1; k >= 0; k--) begin
            text = NAME_TEXT[k];
            same = (NAME_LEN[k] == len);
            for (int i = 0; i < NameMaxLen; i++) begin
                if (3'(i) < NAME_LEN[k] && chars[i] != text[8*i +: 8]) begin
                    same = 1'b0;
                end
            end
            if (same) begin
                r.hit   = 1'b1;
                r.value = NAME_VALUE[k];
            end
        end
        return r;
    endfunction

endpackage

@@ rtl/meu_decode.sv @@
// ----------------------------------------------------------------------------
// meu_decode
// Combinational decode of one byte: next parser state and optional result.
// ----------------------------------------------------------------------------
module meu_decode (
    input  meu_pkg::dec_state_t cur,
    input  logic [7:0]          char_in,
    input  logic                last_in,
    output meu_pkg::dec_state_t nxt,
    output meu_pkg::result_t    res,
    output logic                emit
);

    meu_pkg::lookup_t lk;
    logic [1:0]       status;
    logic [7:0]       dec;
    logic             have;

    assign lk = meu_pkg::lookup_name(cur.name_chars, cur.name_length);

    always_comb begin
        nxt    = cur;
        res    = '0;
        emit   = 1'b0;
        status = meu_pkg::ST_OK;
        dec    = '0;
        have   = 1'b0;
        if (cur.error_seen) begin
            // drop until the end of the string
            if (last_in) begin
                nxt.in_entity   = 1'b0;
                nxt.name_length = '0;
                nxt.error_seen  = 1'b0;
                emit            = 1'b1;
                res.last_out    = 1'b1;
            end
        end else begin
            if (!cur.in_entity) begin
                if (char_in == meu_pkg::CH_AMP) begin
                    nxt.in_entity   = 1'b1;
                    nxt.name_length = '0;
                end else if (char_in == meu_pkg::CH_APOS || char_in == meu_pkg::CH_QUOT ||
                             char_in == meu_pkg::CH_LT || char_in == meu_pkg::CH_GT) begin
                    status = meu_pkg::ST_FORBIDDEN;
                end else begin
                    dec  = char_in;
                    have = 1'b1;
                end
            end else if (char_in == meu_pkg::CH_SEMI) begin
                if (lk.hit) begin
                    dec             = lk.value;
                    have            = 1'b1;
                    nxt.in_entity   = 1'b0;
                    nxt.name_length = '0;
                end else begin
                    status = meu_pkg::ST_UNKNOWN;
                end
            end else if (cur.name_length >= 3'(meu_pkg::NameMaxLen)) begin
                status = meu_pkg::ST_UNKNOWN;
            end else begin
                nxt.name_chars[cur.name_length[1:0]] = char_in;
                nxt.name_length = cur.name_length + 3'd1;
            end

            if (status != meu_pkg::ST_OK) begin
                nxt.in_entity   = 1'b0;
                nxt.name_length = '0;
                nxt.error_seen  = !last_in;
                emit            = 1'b1;
                res.status      = status;
                res.last_out    = last_in;
            end else if (last_in) begin
                emit         = 1'b1;
                res.last_out = 1'b1;
                if (nxt.in_entity) begin
                    res.status = meu_pkg::ST_OPEN_END;
                end else begin
                    res.char_out   = have ? dec : 8'h00;
                    res.char_valid = have;
                end
                nxt.in_entity   = 1'b0;
                nxt.name_length = '0;
                nxt.error_seen  = 1'b0;
            end else if (have) begin
                emit           = 1'b1;
                res.char_out   = dec;
                res.char_valid = 1'b1;
            end
        end
    end

endmodule

@@ rtl/meu_out_reg.sv @@
// ----------------------------------------------------------------------------
// meu_out_reg
// Result register holding one result until the downstream transfer.
// ----------------------------------------------------------------------------
module meu_out_reg (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             load,
    input  meu_pkg::result_t load_data,
    output logic             can_load,
    output logic             m_valid,
    input  logic             m_ready,
    output meu_pkg::result_t m_data
);

    logic             valid_reg;
    meu_pkg::result_t data_reg;

    assign can_load = !valid_reg || m_ready;
    assign m_valid  = valid_reg;
    assign m_data   = data_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else if (can_load) begin
            valid_reg <= load;
        end
    end

    always_ff @(posedge aclk) begin
        if (load && can_load) begin
            data_reg <= load_data;
        end
    end

endmodule

@@ rtl/markup_entity_unescape.sv @@
// ----------------------------------------------------------------------------
// markup_entity_unescape
// Streaming decoder for escaped markup text, one byte per cycle while results can be stored.
// ----------------------------------------------------------------------------
// Input channel s_*: one byte of escaped text per transfer, s_last_in on the
// final byte of a string. Result channel m_*: decoded byte with char_valid,
// a status code and last_out. Bytes that start or extend an entity name, and
// bytes dropped after an error, give no result.
// An accepted byte sits in the input register; from there it is decoded
// against the parser state and, if it gives a result, lands in the result
// register (two-stage pipeline). Throughput is one byte per cycle while the
// result register can take results; the name match against the nine known
// names is a single parallel compare, and the parser state updates in the
// same cycle as the decode.
// When the receiver stalls, the result register holds; a byte that gives no
// result still moves on, and one that gives a result waits in the input
// register, which then stops taking new bytes.
// Synchronous active-low reset empties both registers and returns the parser
// to its idle state between strings.
// ----------------------------------------------------------------------------
module markup_entity_unescape (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_valid,
    output logic       s_ready,
    input  logic [7:0] s_char_in,
    input  logic       s_last_in,
    output logic       m_valid,
    input  logic       m_ready,
    output logic [7:0] m_char_out,
    output logic       m_char_valid,
    output logic [1:0] m_status,
    output logic       m_last_out
);

    logic                in_valid_reg;
    logic [7:0]          in_char_reg;
    logic                in_last_reg;
    meu_pkg::dec_state_t state_reg;
    meu_pkg::dec_state_t state_next;
    meu_pkg::result_t    res;
    meu_pkg::result_t    m_data;
    logic                emit;
    logic                can_load;
    logic                advance;

    meu_decode u_decode (
        .cur     (state_reg),
        .char_in (in_char_reg),
        .last_in (in_last_reg),
        .nxt     (state_next),
        .res     (res),
        .emit    (emit)
    );

    // held byte moves on unless its result cannot be stored
    assign advance = in_valid_reg && (!emit || can_load);
    assign s_ready = !in_valid_reg || advance;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else if (s_ready) begin
            in_valid_reg <= s_valid;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_char_reg <= s_char_in;
            in_last_reg <= s_last_in;
        end
    end

    always_ff @(posedge aclk) begin
        // name bytes need no reset; only written entries are ever compared
        if (advance) begin
            state_reg.name_chars <= state_next.name_chars;
        end
        if (!aresetn) begin
            state_reg.in_entity   <= 1'b0;
            state_reg.name_length <= '0;
            state_reg.error_seen  <= 1'b0;
        end else if (advance) begin
            state_reg.in_entity   <= state_next.in_entity;
            state_reg.name_length <= state_next.name_length;
            state_reg.error_seen  <= state_next.error_seen;
        end
    end

    meu_out_reg u_out_reg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .load      (advance && emit),
        .load_data (res),
        .can_load  (can_load),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data)
    );

    assign m_char_out   = m_data.char_out;
    assign m_char_valid = m_data.char_valid;
    assign m_status     = m_data.status;
    assign m_last_out   = m_data.last_out;

endmodule

@@ tb/meu_stream_checker.sv @@
// ----------------------------------------------------------------------------
// meu_stream_checker
// Watches both channels of the entity unescaper, predicts every result from
// the accepted bytes and compares each result transfer field by field.
// ----------------------------------------------------------------------------
module meu_stream_checker (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_valid,
    input  logic       s_ready,
    input  logic [7:0] s_char_in,
    input  logic       s_last_in,
    input  logic       m_valid,
    input  logic       m_ready,
    input  logic [7:0] m_char_out,
    input  logic       m_char_valid,
    input  logic [1:0] m_status,
    input  logic       m_last_out,
    output int         fault_count,
    output int         results_due
);

    localparam logic [7:0] CH_CR    = 8'h0D;
    localparam logic [7:0] CH_LF    = 8'h0A;
    localparam logic [7:0] CH_TAB   = 8'h09;
    localparam logic [7:0] CH_SPACE = 8'h20;

    typedef struct packed {
        logic                emit;
        meu_pkg::result_t    res;
        meu_pkg::dec_state_t st;
    } decode_step_t;

    meu_pkg::dec_state_t parser = '0;
    meu_pkg::result_t    pending_results [$];
    int                  faults = 0;

    // {hit, byte}; name bytes packed first byte highest, unused bytes zero
    function automatic logic [8:0] entity_value(logic [3:0][7:0] chars, logic [2:0] len);
        logic [31:0] w;
        w = '0;
        for (int i = 0; i < meu_pkg::NameMaxLen; i++) begin
            if (i < len) begin
                w[31-8*i -: 8] = chars[i];
            end
        end
        case ({len, w})
            {3'd4, "apos"}:        return {1'b1, meu_pkg::CH_APOS};
            {3'd4, "quot"}:        return {1'b1, meu_pkg::CH_QUOT};
            {3'd2, "lt", 16'h0}:   return {1'b1, meu_pkg::CH_LT};
            {3'd2, "gt", 16'h0}:   return {1'b1, meu_pkg::CH_GT};
            {3'd3, "amp", 8'h0}:   return {1'b1, meu_pkg::CH_AMP};
            {3'd2, "cr", 16'h0}:   return {1'b1, CH_CR};
            {3'd2, "lf", 16'h0}:   return {1'b1, CH_LF};
            {3'd3, "tab", 8'h0}:   return {1'b1, CH_TAB};
            {3'd4, "spac"}:        return {1'b1, CH_SPACE};
            default:               return 9'h0;
        endcase
    endfunction

    function automatic decode_step_t decode_byte(meu_pkg::dec_state_t st, logic [7:0] c,
                                                 logic lst);
        decode_step_t s;
        logic [8:0]   lk;
        logic [7:0]   dv;
        logic         have;
        logic [1:0]   code;
        s    = '0;
        s.st = st;
        dv   = 8'h00;
        have = 1'b0;
        code = meu_pkg::ST_OK;
        // rest of the string is dropped after an error; only the end marker
        if (st.error_seen) begin
            if (lst) begin
                s.emit = 1'b1;
                s.res  = '{8'h00, 1'b0, meu_pkg::ST_OK, 1'b1};
                s.st.in_entity   = 1'b0;
                s.st.name_length = '0;
                s.st.error_seen  = 1'b0;
            end
            return s;
        end
        if (!st.in_entity) begin
            if (c == meu_pkg::CH_AMP) begin
                s.st.in_entity   = 1'b1;
                s.st.name_length = '0;
            end else if (c == meu_pkg::CH_APOS || c == meu_pkg::CH_QUOT ||
                         c == meu_pkg::CH_LT || c == meu_pkg::CH_GT) begin
                code = meu_pkg::ST_FORBIDDEN;
            end else begin
                dv   = c;
                have = 1'b1;
            end
        end else if (c == meu_pkg::CH_SEMI) begin
            lk = entity_value(st.name_chars, st.name_length);
            if (lk[8]) begin
                dv   = lk[7:0];
                have = 1'b1;
                s.st.in_entity   = 1'b0;
                s.st.name_length = '0;
            end else begin
                code = meu_pkg::ST_UNKNOWN;
            end
        end else if (st.name_length >= 3'(meu_pkg::NameMaxLen)) begin
            code = meu_pkg::ST_UNKNOWN;
        end else begin
            s.st.name_chars[st.name_length[1:0]] = c;
            s.st.name_length = st.name_length + 3'd1;
        end

        if (code != meu_pkg::ST_OK) begin
            s.emit = 1'b1;
            s.res  = '{8'h00, 1'b0, code, lst};
            s.st.in_entity   = 1'b0;
            s.st.name_length = '0;
            s.st.error_seen  = !lst;
        end else if (lst) begin
            s.emit = 1'b1;
            if (s.st.in_entity) begin
                s.res = '{8'h00, 1'b0, meu_pkg::ST_OPEN_END, 1'b1};
            end else begin
                s.res = '{(have ? dv : 8'h00), have, meu_pkg::ST_OK, 1'b1};
            end
            s.st.in_entity   = 1'b0;
            s.st.name_length = '0;
            s.st.error_seen  = 1'b0;
        end else if (have) begin
            s.emit = 1'b1;
            s.res  = '{dv, 1'b1, meu_pkg::ST_OK, 1'b0};
        end
        return s;
    endfunction

    always @(posedge aclk) begin
        decode_step_t     step;
        meu_pkg::result_t want;
        if (!aresetn) begin
            parser = '0;
            pending_results.delete();
        end else begin
            // results leave before the byte of this edge can add one
            if (m_valid && m_ready) begin
                if (pending_results.size() == 0) begin
                    $error("result transfer with nothing expected: char_out=%h status=%0d",
                           m_char_out, m_status);
                    faults++;
                end else begin
                    want = pending_results.pop_front();
                    if (m_char_out !== want.char_out) begin
                        $error("char_out: expected %h, actual %h", want.char_out, m_char_out);
                        faults++;
                    end
                    if (m_char_valid !== want.char_valid) begin
                        $error("char_valid: expected %b, actual %b",
                               want.char_valid, m_char_valid);
                        faults++;
                    end
                    if (m_status !== want.status) begin
                        $error("status: expected %0d, actual %0d", want.status, m_status);
                        faults++;
                    end
                    if (m_last_out !== want.last_out) begin
                        $error("last_out: expected %b, actual %b", want.last_out, m_last_out);
                        faults++;
                    end
                end
            end
            if (s_valid && s_ready) begin
                step   = decode_byte(parser, s_char_in, s_last_in);
                parser = step.st;
                if (step.emit) begin
                    pending_results.push_back(step.res);
                end
            end
        end
        results_due <= pending_results.size();
        fault_count <= faults;
    end

endmodule

@@ tb/markup_entity_unescape_tb.sv @@
// ----------------------------------------------------------------------------
// markup_entity_unescape_tb
// Drives escaped text strings into the entity unescaper with random idling on
// both channels; the stream checker predicts and compares all results.
// ----------------------------------------------------------------------------
module markup_entity_unescape_tb;

    localparam int ItemTarget  = 2000;
    localparam int IdleLimit   = 5000;
    localparam int LongHoldAt  = 200;
    localparam int LongHoldLen = 300;

    logic       aclk;
    logic       aresetn;
    logic       s_valid;
    logic       s_ready;
    logic [7:0] s_char_in;
    logic       s_last_in;
    logic       m_valid;
    logic       m_ready;
    logic [7:0] m_char_out;
    logic       m_char_valid;
    logic [1:0] m_status;
    logic       m_last_out;
    int         fault_count;
    int         results_due;

    logic [7:0] text_q [$];
    int         bytes_sent;
    string      entity_names [meu_pkg::NameCount] = '{
        "apos", "quot", "lt", "gt", "amp", "cr", "lf", "tab", "spac"
    };

    markup_entity_unescape u_dut (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_char_in    (s_char_in),
        .s_last_in    (s_last_in),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_char_out   (m_char_out),
        .m_char_valid (m_char_valid),
        .m_status     (m_status),
        .m_last_out   (m_last_out)
    );

    meu_stream_checker u_chk (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_char_in    (s_char_in),
        .s_last_in    (s_last_in),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_char_out   (m_char_out),
        .m_char_valid (m_char_valid),
        .m_status     (m_status),
        .m_last_out   (m_last_out),
        .fault_count  (fault_count),
        .results_due  (results_due)
    );

    initial begin
        aclk = 1'b0;
        forever #5 aclk = ~aclk;
    end

    // any byte except the entity opener and the raw forbidden ones
    function automatic logic [7:0] plain_byte();
        logic [7:0] b;
        b = 8'($urandom_range(0, 255));
        if (b == meu_pkg::CH_AMP || b == meu_pkg::CH_APOS || b == meu_pkg::CH_QUOT ||
            b == meu_pkg::CH_LT || b == meu_pkg::CH_GT) begin
            b = b ^ 8'h40;
        end
        return b;
    endfunction

    function automatic logic [7:0] forbidden_byte();
        case ($urandom_range(0, 3))
            0:       return meu_pkg::CH_APOS;
            1:       return meu_pkg::CH_QUOT;
            2:       return meu_pkg::CH_LT;
            default: return meu_pkg::CH_GT;
        endcase
    endfunction

    function automatic logic [7:0] name_byte();
        if ($urandom_range(0, 4) != 0) begin
            return 8'($urandom_range(8'h61, 8'h7A));
        end
        return 8'($urandom_range(0, 255));
    endfunction

    function automatic logic [7:0] noise_byte();
        int r;
        r = $urandom_range(0, 99);
        if (r < 30) return meu_pkg::CH_AMP;
        if (r < 40) return meu_pkg::CH_SEMI;
        if (r < 55) return forbidden_byte();
        if (r < 80) return 8'($urandom_range(8'h61, 8'h7A));
        return 8'($urandom_range(0, 255));
    endfunction

    task automatic push_text(input string t);
        for (int i = 0; i < t.len(); i++) begin
            text_q.push_back(t[i]);
        end
    endtask

    task automatic send_byte(input logic [7:0] b, input logic lst);
        int r;
        int gap;
        r   = $urandom_range(0, 99);
        gap = (r < 60) ? 0 : (r < 95) ? $urandom_range(1, 3) : $urandom_range(10, 40);
        if (gap > 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid   <= 1'b1;
        s_char_in <= b;
        s_last_in <= lst;
        do @(posedge aclk); while (!s_ready);
        bytes_sent++;
    endtask

    // sends the queued string with last on its final byte
    task automatic send_text();
        for (int i = 0; i < text_q.size(); i++) begin
            send_byte(text_q[i], i == text_q.size() - 1);
        end
        text_q.delete();
    endtask

    task automatic build_random_text();
        int kind;
        int segs;
        int r;
        kind = $urandom_range(0, 99);
        if (kind < 75) begin
            segs = $urandom_range(1, 6);
            repeat (segs) begin
                r = $urandom_range(0, 99);
                if (r < 45) begin
                    text_q.push_back(plain_byte());
                end else if (r < 85) begin
                    text_q.push_back(meu_pkg::CH_AMP);
                    push_text(entity_names[$urandom_range(0, meu_pkg::NameCount - 1)]);
                    text_q.push_back(meu_pkg::CH_SEMI);
                end else if (r < 93) begin
                    text_q.push_back(meu_pkg::CH_AMP);
                    repeat ($urandom_range(0, 5)) text_q.push_back(name_byte());
                    text_q.push_back(meu_pkg::CH_SEMI);
                end else begin
                    text_q.push_back(forbidden_byte());
                end
            end
            // sometimes leave an entity open at the end
            if ($urandom_range(0, 9) == 0) begin
                text_q.push_back(meu_pkg::CH_AMP);
                repeat ($urandom_range(0, 3)) text_q.push_back(name_byte());
            end
        end else begin
            repeat ($urandom_range(1, 10)) text_q.push_back(noise_byte());
        end
    endtask

    task automatic wait_drained();
        s_valid <= 1'b0;
        do @(posedge aclk); while (results_due != 0);
    endtask

    // receiver: random ready pattern, one long hold-off to back up the input
    initial begin
        int r;
        int rounds;
        rounds  = 0;
        m_ready = 1'b0;
        wait (aresetn);
        forever begin
            rounds++;
            r = $urandom_range(0, 99);
            if (rounds == LongHoldAt) begin
                m_ready <= 1'b0;
                repeat (LongHoldLen) @(posedge aclk);
            end else if (r < 50) begin
                m_ready <= 1'b1;
                repeat ($urandom_range(1, 30)) @(posedge aclk);
            end else if (r < 95) begin
                m_ready <= 1'b0;
                repeat ($urandom_range(1, 3)) @(posedge aclk);
            end else begin
                m_ready <= 1'b0;
                repeat ($urandom_range(10, 60)) @(posedge aclk);
            end
        end
    end

    // watchdog on cycles without any transfer
    initial begin
        int idle_cycles;
        idle_cycles = 0;
        while (idle_cycles < IdleLimit) begin
            @(posedge aclk);
            if ((s_valid && s_ready) || (m_valid && m_ready) || !aresetn) begin
                idle_cycles = 0;
            end else begin
                idle_cycles++;
            end
        end
        $display("markup_entity_unescape verification failed");
        $finish;
    end

    initial begin
        bit paused;
        paused     = 1'b0;
        bytes_sent = 0;
        aresetn    = 1'b0;
        s_valid    = 1'b0;
        s_char_in  = 8'h00;
        s_last_in  = 1'b0;
        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;

        // directed strings
        text_q.push_back(8'h00);
        text_q.push_back(8'hFF);
        send_text();
        push_text("&lt;");
        send_text();
        text_q.push_back(meu_pkg::CH_APOS);     // raw quote, then dropped bytes
        push_text("qz");
        send_text();
        push_text("&;");                // empty name, error on final byte
        send_text();
        push_text("&abcde");            // fifth name byte
        send_text();
        push_text("&gt");               // ends inside entity
        send_text();
        push_text("&");
        send_text();
        text_q.push_back(meu_pkg::CH_QUOT);
        send_text();
        text_q.push_back(meu_pkg::CH_LT);
        send_text();
        text_q.push_back(meu_pkg::CH_GT);
        send_text();
        wait_drained();

        while (bytes_sent < ItemTarget) begin
            build_random_text();
            send_text();
            if (!paused && bytes_sent >= ItemTarget / 2) begin
                paused = 1'b1;
                wait_drained();
            end
        end

        wait_drained();
        repeat (8) @(posedge aclk);
        if (fault_count == 0 && results_due == 0) begin
            $display("markup_entity_unescape verification clean");
        end else begin
            $display("markup_entity_unescape verification failed");
        end
        $finish;
    end

endmodule

@@ filelist.f @@
rtl/meu_pkg.sv
rtl/meu_decode.sv
rtl/meu_out_reg.sv
rtl/markup_entity_unescape.sv
tb/meu_stream_checker.sv
tb/markup_entity_unescape_tb.sv
